// File: hdl/tbse_pkg.sv
// shared types and constants for the truss bar stiffness entry generator
// no dependencies
`default_nettype none
package tbse_pkg;

  localparam int unsigned MaxNodesDef   = 4096;
  localparam int unsigned DofPerNodeDef = 6;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned NodeW         = 12;
  localparam int unsigned IdxW          = 15;
  localparam int unsigned ValW          = 64;
  localparam int unsigned LenW          = 34;
  localparam int unsigned CosW          = 31;
  localparam int unsigned QuotW         = 81;
  localparam int unsigned FifoDepth     = 2;

  typedef struct packed {
    logic                          zero;
    logic [LenW-1:0]               len;
    logic [2:0][CosW-1:0]          cosv;
    logic [2:0]                    neg;
    logic [63:0]                   ea;
    logic [IdxW-1:0]               base0;
    logic [IdxW-1:0]               base1;
  } desc_t;

  typedef struct packed {
    logic                          zero;
    logic [QuotW-1:0]              quot;
    logic [1:0]                    i;
    logic [1:0]                    j;
    logic                          neg_i;
    logic                          neg_j;
    logic [IdxW-1:0]               base0;
    logic [IdxW-1:0]               base1;
    logic                          last;
  } job_t;

endpackage
`default_nettype wire

// File: hdl/tbse_if.sv
// valid/ready channel interfaces for bars in and entries out
// depends on tbse_pkg
`default_nettype none
interface tbse_bar_if;
  logic                            valid;
  logic                            ready;
  logic signed [tbse_pkg::CoordW-1:0] first_x;
  logic signed [tbse_pkg::CoordW-1:0] first_y;
  logic signed [tbse_pkg::CoordW-1:0] first_z;
  logic signed [tbse_pkg::CoordW-1:0] second_x;
  logic signed [tbse_pkg::CoordW-1:0] second_y;
  logic signed [tbse_pkg::CoordW-1:0] second_z;
  logic [tbse_pkg::NodeW-1:0]      first_node;
  logic [tbse_pkg::NodeW-1:0]      second_node;
  logic [31:0]                     modulus;
  logic [31:0]                     area;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  first_node, second_node, modulus, area, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                first_node, second_node, modulus, area, output ready);
endinterface

interface tbse_ent_if;
  logic                            valid;
  logic                            ready;
  logic [tbse_pkg::IdxW-1:0]       row;
  logic [tbse_pkg::IdxW-1:0]       col;
  logic signed [tbse_pkg::ValW-1:0] value;
  logic                            last;
  logic                            zero_length;
  modport source (output valid, row, col, value, last, zero_length, input ready);
  modport sink (input valid, row, col, value, last, zero_length, output ready);
endinterface
`default_nettype wire

// File: hdl/truss_bar_stiffness_entries_top.sv
// Truss bar stiffness entry generator. Each bar taken on bar_i leaves as 36
// entries on ent_o (or one zero_length item), last marked on the final one.
// The front computes length by a 34-step digit square root and the three
// direction cosines by a 63-step serial divider, and runs ahead of the back
// through a two-deep descriptor queue. For each cosine pair the back does a
// split 64x61 multiply and an 81-step serial divide by length, and that
// back-end divider sets the bar rate; each pair's four entries drain while
// the next pair is computed. A bar is taken whenever the input holding
// register is free.
// depends on tbse_pkg, tbse_if, tbse_front, tbse_fifo, tbse_back, tbse_emit
`default_nettype none
module truss_bar_stiffness_entries_top #(
  parameter int unsigned MAX_NODES    = tbse_pkg::MaxNodesDef,
  parameter int unsigned DOF_PER_NODE = tbse_pkg::DofPerNodeDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tbse_bar_if.sink  bar_i,
  tbse_ent_if.source ent_o
);

  tbse_pkg::desc_t desc_in, desc_out;
  tbse_pkg::job_t  job;
  logic push, full, pop, empty, job_vld, job_rdy;

  tbse_front #(
    .MAX_NODES    (MAX_NODES),
    .DOF_PER_NODE (DOF_PER_NODE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bar_i  (bar_i),
    .desc_o (desc_in),
    .push_o (push),
    .full_i (full)
  );

  tbse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (desc_out),
    .empty_o (empty)
  );

  tbse_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .desc_i    (desc_out),
    .empty_i   (empty),
    .pop_o     (pop),
    .job_o     (job),
    .job_vld_o (job_vld),
    .job_rdy_i (job_rdy)
  );

  tbse_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .job_vld_i (job_vld),
    .job_rdy_o (job_rdy),
    .ent_o     (ent_o)
  );

endmodule
`default_nettype wire

// File: hdl/tbse_front.sv
// front end: takes a bar, finds length by digit sqrt and cosines by serial division
// depends on tbse_pkg, tbse_if
`default_nettype none
module tbse_front #(
  parameter int unsigned MAX_NODES    = tbse_pkg::MaxNodesDef,
  parameter int unsigned DOF_PER_NODE = tbse_pkg::DofPerNodeDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tbse_bar_if.sink             bar_i,
  output tbse_pkg::desc_t      desc_o,
  output logic                 push_o,
  input  wire logic            full_i
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_SQRT = 3'd2;
  localparam logic [2:0] F_COS  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        hold_vld_q, hold_vld_d;
  logic signed [2:0][31:0] p1_q, p2_q;
  logic [tbse_pkg::NodeW-1:0] n1_q, n2_q;
  logic [31:0] mod_q, area_q;
  logic [2:0][32:0] mag_q, mag_d;
  logic [2:0]  neg_q, neg_d;
  logic [63:0] ea_q, ea_d;
  logic [tbse_pkg::IdxW-1:0] b0_q, b0_d, b1_q, b1_d;
  logic        zero_q, zero_d;
  logic [67:0] sacc_q, sacc_d;
  logic [tbse_pkg::LenW-1:0] root_q, root_d;
  logic [36:0] srem_q, srem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [2:0][62:0] cdiv_q, cdiv_d;
  logic [2:0][33:0] crem_q, crem_d;

  logic        take;
  logic signed [32:0] dif [3];
  logic [65:0] sq;
  logic [36:0] rem_sh, trial;
  logic [34:0] rs [3];

  function automatic logic [tbse_pkg::IdxW-1:0] node_base(logic [tbse_pkg::NodeW-1:0] n);
    logic [31:0] nb;
    logic [31:0] prod;
    nb   = (32'(n) >= 32'(MAX_NODES)) ? 32'(MAX_NODES - 1) : 32'(n);
    prod = nb * 32'(DOF_PER_NODE);
    return prod[tbse_pkg::IdxW-1:0];
  endfunction

  assign bar_i.ready = !hold_vld_q;
  assign take        = bar_i.valid && !hold_vld_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      p1_q   <= {bar_i.first_z, bar_i.first_y, bar_i.first_x};
      p2_q   <= {bar_i.second_z, bar_i.second_y, bar_i.second_x};
      n1_q   <= bar_i.first_node;
      n2_q   <= bar_i.second_node;
      mod_q  <= bar_i.modulus;
      area_q <= bar_i.area;
    end
  end

  always_comb begin
    state_d    = state_q;
    hold_vld_d = hold_vld_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    ea_d       = ea_q;
    b0_d       = b0_q;
    b1_d       = b1_q;
    zero_d     = zero_q;
    sacc_d     = sacc_q;
    root_d     = root_q;
    srem_d     = srem_q;
    cnt_d      = cnt_q;
    cdiv_d     = cdiv_q;
    crem_d     = crem_q;
    push_o     = 1'b0;
    sq         = mag_q[cnt_q[1:0]] * mag_q[cnt_q[1:0]];
    rem_sh     = {srem_q[34:0], sacc_q[67:66]};
    trial      = {1'b0, root_q, 2'b01};
    for (int k = 0; k < 3; k++) begin
      dif[k] = {p2_q[k][31], p2_q[k]} - {p1_q[k][31], p1_q[k]};
      rs[k]  = {crem_q[k], cdiv_q[k][62]};
    end
    if (take) hold_vld_d = 1'b1;
    case (state_q)
      F_IDLE: begin
        if (hold_vld_q) begin
          hold_vld_d = 1'b0;
          for (int k = 0; k < 3; k++) begin
            neg_d[k] = dif[k][32];
            mag_d[k] = dif[k][32] ? 33'(-dif[k]) : 33'(dif[k]);
          end
          zero_d  = (mag_d[0] == '0) && (mag_d[1] == '0) && (mag_d[2] == '0);
          ea_d    = mod_q * area_q;
          b0_d    = node_base(n1_q);
          b1_d    = node_base(n2_q);
          sacc_d  = '0;
          cnt_d   = '0;
          state_d = zero_d ? F_PUSH : F_SQ;
        end
      end
      F_SQ: begin
        sacc_d = sacc_q + {2'b00, sq};
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'd2) begin
          cnt_d   = '0;
          root_d  = '0;
          srem_d  = '0;
          state_d = F_SQRT;
        end
      end
      F_SQRT: begin
        sacc_d = {sacc_q[65:0], 2'b00};
        if (rem_sh >= trial) begin
          srem_d = rem_sh - trial;
          root_d = {root_q[tbse_pkg::LenW-2:0], 1'b1};
        end else begin
          srem_d = rem_sh;
          root_d = {root_q[tbse_pkg::LenW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(tbse_pkg::LenW - 1)) begin
          cnt_d = '0;
          for (int k = 0; k < 3; k++) begin
            cdiv_d[k] = {mag_q[k], 30'b0};
            crem_d[k] = '0;
          end
          state_d = F_COS;
        end
      end
      F_COS: begin
        for (int k = 0; k < 3; k++) begin
          if (rs[k] >= {1'b0, root_q}) begin
            crem_d[k] = 34'(rs[k] - {1'b0, root_q});
            cdiv_d[k] = {cdiv_q[k][61:0], 1'b1};
          end else begin
            crem_d[k] = rs[k][33:0];
            cdiv_d[k] = {cdiv_q[k][61:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd62) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    desc_o.zero  = zero_q;
    desc_o.len   = root_q;
    for (int k = 0; k < 3; k++) desc_o.cosv[k] = cdiv_q[k][tbse_pkg::CosW-1:0];
    desc_o.neg   = neg_q;
    desc_o.ea    = ea_q;
    desc_o.base0 = b0_q;
    desc_o.base1 = b1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      hold_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    ea_q   <= ea_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    zero_q <= zero_d;
    sacc_q <= sacc_d;
    root_q <= root_d;
    srem_q <= srem_d;
    cdiv_q <= cdiv_d;
    crem_q <= crem_d;
  end

endmodule
`default_nettype wire

// File: hdl/tbse_fifo.sv
// short queue of bar descriptors between front and back
// depends on tbse_pkg
`default_nettype none
module tbse_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tbse_pkg::desc_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output tbse_pkg::desc_t      data_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = $clog2(tbse_pkg::FifoDepth);

  tbse_pkg::desc_t mem_q [tbse_pkg::FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(tbse_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= PtrW'((32'(wr_q) + 1) % tbse_pkg::FifoDepth);
      if (pop_i)  rd_q <= PtrW'((32'(rd_q) + 1) % tbse_pkg::FifoDepth);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// File: hdl/tbse_back.sv
// back end: per cosine pair, multiplies E*A*ci*cj and divides by length serially
// depends on tbse_pkg
`default_nettype none
module tbse_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tbse_pkg::desc_t desc_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output tbse_pkg::job_t       job_o,
  output logic                 job_vld_o,
  input  wire logic            job_rdy_i
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CC    = 3'd1;
  localparam logic [2:0] B_MUL   = 3'd2;
  localparam logic [2:0] B_DLOAD = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_HAND  = 3'd5;
  localparam logic [2:0] B_ZERO  = 3'd6;

  logic [2:0]  state_q, state_d;
  tbse_pkg::desc_t desc_q, desc_d;
  logic [1:0]  i_q, i_d, j_q, j_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [60:0] cc_q, cc_d;
  logic [124:0] acc_q, acc_d;
  logic [tbse_pkg::QuotW-1:0] y_q, y_d;
  logic [tbse_pkg::LenW-1:0] rem_q, rem_d;

  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [61:0] ccp;
  logic [tbse_pkg::LenW:0] rs;
  logic        last_pair;

  assign last_pair = (i_q == 2'd2) && (j_q == 2'd2);

  always_comb begin
    state_d = state_q;
    desc_d  = desc_q;
    i_d     = i_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    cc_d    = cc_q;
    acc_d   = acc_q;
    y_d     = y_q;
    rem_d   = rem_q;
    pop_o   = 1'b0;
    job_vld_o = 1'b0;
    ccp     = desc_q.cosv[i_q] * desc_q.cosv[j_q];
    ma      = cnt_q[1] ? desc_q.ea[63:32] : desc_q.ea[31:0];
    mb      = cnt_q[0] ? {3'b000, cc_q[60:32]} : cc_q[31:0];
    mp      = ma * mb;
    rs      = {rem_q, y_q[tbse_pkg::QuotW-1]};

    job_o.zero  = desc_q.zero;
    job_o.quot  = y_q;
    job_o.i     = i_q;
    job_o.j     = j_q;
    job_o.neg_i = desc_q.neg[i_q];
    job_o.neg_j = desc_q.neg[j_q];
    job_o.base0 = desc_q.base0;
    job_o.base1 = desc_q.base1;
    job_o.last  = last_pair;

    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          desc_d  = desc_i;
          i_d     = '0;
          j_d     = '0;
          state_d = desc_i.zero ? B_ZERO : B_CC;
        end
      end
      B_CC: begin
        cc_d    = ccp[60:0];
        acc_d   = '0;
        cnt_d   = '0;
        state_d = B_MUL;
      end
      B_MUL: begin
        case (cnt_q[1:0])
          2'd0:    acc_d = acc_q + 125'(mp);
          2'd3:    acc_d = acc_q + {61'(mp), 64'b0};
          default: acc_d = acc_q + {29'b0, mp, 32'b0};
        endcase
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd3) state_d = B_DLOAD;
      end
      B_DLOAD: begin
        y_d     = acc_q[124:44];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = B_DIV;
      end
      B_DIV: begin
        if (rs >= {1'b0, desc_q.len}) begin
          rem_d = tbse_pkg::LenW'(rs - {1'b0, desc_q.len});
          y_d   = {y_q[tbse_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_d = rs[tbse_pkg::LenW-1:0];
          y_d   = {y_q[tbse_pkg::QuotW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(tbse_pkg::QuotW - 1)) state_d = B_HAND;
      end
      B_HAND: begin
        job_vld_o = 1'b1;
        if (job_rdy_i) begin
          if (last_pair) begin
            state_d = B_IDLE;
          end else begin
            if (j_q == 2'd2) begin
              j_d = '0;
              i_d = i_q + 2'd1;
            end else begin
              j_d = j_q + 2'd1;
            end
            state_d = B_CC;
          end
        end
      end
      B_ZERO: begin
        job_vld_o = 1'b1;
        if (job_rdy_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    cc_q   <= cc_d;
    acc_q  <= acc_d;
    y_q    <= y_d;
    rem_q  <= rem_d;
  end

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> desc_q.len != '0)
    else $error("divide by zero length");
  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && desc_i.zero |=> state_q == B_ZERO)
    else $error("zero-length bar not routed to error result");
  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_IDLE |-> i_q != 2'd3 && j_q != 2'd3)
    else $error("cosine pair index out of range");

endmodule
`default_nettype wire

// File: hdl/tbse_emit.sv
// output stage: turns one pair result into four signed, saturated entries, or a zero-length job into one
// depends on tbse_pkg, tbse_if
`default_nettype none
module tbse_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tbse_pkg::job_t  job_i,
  input  wire logic            job_vld_i,
  output logic                 job_rdy_o,
  tbse_ent_if.source           ent_o
);

  tbse_pkg::job_t job_q;
  logic        busy_q;
  logic [1:0]  k_q;
  logic        rb, cb, neg;
  logic [63:0] mag;
  logic        done;

  localparam logic [tbse_pkg::QuotW-1:0] PosLim = tbse_pkg::QuotW'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [tbse_pkg::QuotW-1:0] NegLim = tbse_pkg::QuotW'(64'h8000_0000_0000_0000);

  assign job_rdy_o = !busy_q;
  assign rb        = k_q[0];
  assign cb        = k_q[1];
  assign neg       = (job_q.neg_i ^ job_q.neg_j) ^ (rb ^ cb);
  assign done      = job_q.zero || (k_q == 2'd3);

  always_comb begin
    if (neg) mag = (job_q.quot > NegLim) ? NegLim[63:0] : job_q.quot[63:0];
    else     mag = (job_q.quot > PosLim) ? PosLim[63:0] : job_q.quot[63:0];
  end

  assign ent_o.valid       = busy_q;
  assign ent_o.zero_length = job_q.zero;
  assign ent_o.last        = job_q.zero || (job_q.last && (k_q == 2'd3));
  assign ent_o.row   = job_q.zero ? '0 :
                       (rb ? job_q.base1 : job_q.base0) + tbse_pkg::IdxW'(job_q.i);
  assign ent_o.col   = job_q.zero ? '0 :
                       (cb ? job_q.base1 : job_q.base0) + tbse_pkg::IdxW'(job_q.j);
  assign ent_o.value = job_q.zero ? '0 : (neg ? 64'(-mag) : mag);

  always_ff @(posedge clk_i) begin
    if (job_vld_i && !busy_q) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (!busy_q) begin
      if (job_vld_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end
    end else if (ent_o.ready) begin
      if (done) busy_q <= 1'b0;
      else      k_q    <= k_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_truss_bar_stiffness_entries_top.sv
// testbench for the truss bar stiffness entry generator: drives a directed table
// and random bars, predicts 36 entries a bar (one if zero length), checks them
// depends on tbse_pkg, tbse_if, truss_bar_stiffness_entries_top
`timescale 1ns / 1ps
module tb_truss_bar_stiffness_entries_top;

  typedef struct packed {
    logic [tbse_pkg::IdxW-1:0] row;
    logic [tbse_pkg::IdxW-1:0] col;
    logic [tbse_pkg::ValW-1:0] value;
    logic                      last;
    logic                      zero_length;
  } entry_t;

  typedef struct {
    logic [31:0]                fx, fy, fz, sx, sy, sz;
    logic [tbse_pkg::NodeW-1:0] n0, n1;
    logic [31:0]                e, a;
    bit                         has_typed;
    entry_t                     typed;
  } bar_t;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  tbse_bar_if bar_if ();
  tbse_ent_if ent_if ();

  truss_bar_stiffness_entries_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .bar_i (bar_if.sink),
    .ent_o (ent_if.source)
  );

  entry_t    entry_q[$];
  int        err_cnt = 0;
  int        idle_cnt = 0;
  int        sink_idle_pct = 0;
  bar_t      dir_tab[$];

  function automatic logic [33:0] isqrt(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (34'd1 << b);
      if ({34'd0, t} * {34'd0, t} <= s) r = t;
    end
    return r;
  endfunction

  task automatic predict_entries(input bar_t b);
    logic signed [32:0]        d[3];
    logic [32:0]               mg[3];
    logic                      ng[3];
    logic [67:0]               s;
    logic [33:0]               len;
    logic [62:0]               cs[3];
    logic [63:0]               ea;
    logic [tbse_pkg::IdxW-1:0] base[2];
    logic [127:0]              q;
    logic [63:0]               m, lim, v;
    logic                      big, negative;
    int                        n;
    entry_t                    ent;
    d[0] = $signed(b.sx) - $signed(b.fx);
    d[1] = $signed(b.sy) - $signed(b.fy);
    d[2] = $signed(b.sz) - $signed(b.fz);
    s = '0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = d[i][32];
      mg[i] = ng[i] ? -d[i] : d[i];
      s += {35'd0, mg[i]} * {35'd0, mg[i]};
    end
    if (s == 0) begin
      ent = '{row: '0, col: '0, value: '0, last: 1'b1, zero_length: 1'b1};
      entry_q.push_back(ent);
      return;
    end
    len = isqrt(s);
    for (int i = 0; i < 3; i++) cs[i] = ({30'd0, mg[i]} << 30) / {29'd0, len};
    ea = {32'd0, b.e} * {32'd0, b.a};
    base[0] = tbse_pkg::IdxW'((b.n0 >= tbse_pkg::MaxNodesDef ? tbse_pkg::MaxNodesDef - 1 :
                               b.n0) * tbse_pkg::DofPerNodeDef);
    base[1] = tbse_pkg::IdxW'((b.n1 >= tbse_pkg::MaxNodesDef ? tbse_pkg::MaxNodesDef - 1 :
                               b.n1) * tbse_pkg::DofPerNodeDef);
    n = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q = ({64'd0, ea} * {64'd0, {1'b0, cs[i]} * {1'b0, cs[j]}}) / {94'd0, len};
        m = q[107:44];
        big = q[127:108] != 0;
        for (int k = 0; k < 4; k++) begin
          negative = (ng[i] != ng[j]) != ((k & 1) != (k >> 1));
          lim = negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          v = (big || m > lim) ? lim : m;
          ent.row = base[k & 1] + tbse_pkg::IdxW'(i);
          ent.col = base[k >> 1] + tbse_pkg::IdxW'(j);
          ent.value = negative ? -v : v;
          ent.last = (n == 35);
          ent.zero_length = 1'b0;
          entry_q.push_back(ent);
          n++;
        end
      end
    end
  endtask

  function automatic bar_t rand_bar();
    bar_t b;
    int   mode;
    mode = $urandom_range(0, 9);
    b.fx = $urandom; b.fy = $urandom; b.fz = $urandom;
    b.sx = $urandom; b.sy = $urandom; b.sz = $urandom;
    if (mode < 6) begin
      b.sx = b.fx + $urandom_range(0, 1 << 20) - (1 << 19);
      b.sy = b.fy + $urandom_range(0, 1 << 20) - (1 << 19);
      b.sz = b.fz + $urandom_range(0, 1 << 20) - (1 << 19);
    end else if (mode == 6) begin
      b.sx = b.fx; b.sy = b.fy; b.sz = b.fz + $urandom_range(0, 1);
    end
    b.n0 = tbse_pkg::NodeW'($urandom);
    b.n1 = ($urandom_range(0, 7) == 0) ? b.n0 : tbse_pkg::NodeW'($urandom);
    b.e = $urandom; b.a = $urandom;
    if (mode == 7) begin b.e = $urandom_range(0, 1 << 18); b.a = $urandom_range(0, 1 << 18); end
    b.has_typed = 1'b0;
    b.typed = '0;
    return b;
  endfunction

  function automatic bar_t mk(logic [31:0] fx, fy, fz, sx, sy, sz,
                              logic [tbse_pkg::NodeW-1:0] n0, n1, logic [31:0] e, a);
    bar_t b;
    b = '{fx, fy, fz, sx, sy, sz, n0, n1, e, a, 1'b0, '0};
    return b;
  endfunction

  task automatic send_bar(input bar_t b, input int gap_pct);
    while ($urandom_range(0, 99) < gap_pct) begin
      bar_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bar_if.valid <= 1'b1;
    bar_if.first_x <= b.fx; bar_if.first_y <= b.fy; bar_if.first_z <= b.fz;
    bar_if.second_x <= b.sx; bar_if.second_y <= b.sy; bar_if.second_z <= b.sz;
    bar_if.first_node <= b.n0; bar_if.second_node <= b.n1;
    bar_if.modulus <= b.e; bar_if.area <= b.a;
    do @(posedge clk_i); while (!bar_if.ready);
    if (b.has_typed) entry_q.push_back(b.typed);
    else predict_entries(b);
  endtask

  always @(posedge clk_i) begin
    entry_t exp_e;
    if (!rst_ni) begin
      ent_if.ready <= 1'b0;
    end else begin
      ent_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      if (ent_if.valid && ent_if.ready) begin
        idle_cnt <= 0;
        if (entry_q.size() == 0) begin
          $error("entry with none expected");
          err_cnt++;
        end else begin
          exp_e = entry_q.pop_front();
          if (ent_if.row !== exp_e.row) begin
            $error("row exp %0d got %0d", exp_e.row, ent_if.row); err_cnt++;
          end
          if (ent_if.col !== exp_e.col) begin
            $error("col exp %0d got %0d", exp_e.col, ent_if.col); err_cnt++;
          end
          if (ent_if.value !== exp_e.value) begin
            $error("value exp %0h got %0h", exp_e.value, ent_if.value); err_cnt++;
          end
          if (ent_if.last !== exp_e.last) begin
            $error("last exp %0b got %0b", exp_e.last, ent_if.last); err_cnt++;
          end
          if (ent_if.zero_length !== exp_e.zero_length) begin
            $error("zero_length exp %0b got %0b", exp_e.zero_length,
                   ent_if.zero_length);
            err_cnt++;
          end
        end
      end else if (bar_if.valid && bar_if.ready) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    entry_t zl;
    bar_if.valid = 1'b0;
    bar_if.first_x = '0; bar_if.first_y = '0; bar_if.first_z = '0;
    bar_if.second_x = '0; bar_if.second_y = '0; bar_if.second_z = '0;
    bar_if.first_node = '0; bar_if.second_node = '0;
    bar_if.modulus = '0; bar_if.area = '0;
    zl = '{row: '0, col: '0, value: '0, last: 1'b1, zero_length: 1'b1};

    // zero length, typed
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 32'h10000, 32'h10000));
    dir_tab[$].has_typed = 1'b1; dir_tab[$].typed = zl;
    dir_tab.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 5, 32'h8000_0000, 32'h7fff_ffff, 5,
                         4095, 4095, '1, '1));
    dir_tab[$].has_typed = 1'b1; dir_tab[$].typed = zl;
    // axis bars, both signs, and a short diagonal bar
    dir_tab.push_back(mk(0, 0, 0, 32'h10000, 0, 0, 0, 1, 32'h10000, 32'h10000));
    dir_tab.push_back(mk(0, 0, 0, 0, 32'hffff_0000, 0, 2, 3, 32'h10000, 32'h10000));
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 32'h20000, 7, 5, 32'h30000, 32'h8000));
    dir_tab.push_back(mk(1, 1, 1, 2, 2, 2, 9, 9, 32'h10000, 32'h10000));
    // coordinate extremes, saturation
    dir_tab.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         4095, 0, '1, '1));
    dir_tab.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0,
                         12, 4000, '1, '1));
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 1, 0, 4095, '1, '1));
    dir_tab.push_back(mk(0, 0, 0, 1, 1, 1, 100, 200, '1, '1));
    dir_tab.push_back(mk(0, 0, 0, 3, 32'hffff_fffc, 12, 1, 0, '1, 32'h1));
    dir_tab.push_back(mk(5, 6, 7, 32'h1234_5678, 32'h8765_4321, 32'h0fed_cba9, 4094, 4093,
                         0, '1));
    dir_tab.push_back(mk(0, 0, 0, 32'h10000, 32'h10000, 0, 33, 34, 32'h1, 0));
    dir_tab.push_back(mk(32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 1, 2048, 2047,
                         32'haaaa_aaaa, 32'h5555_5555));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) send_bar(dir_tab[k], 0);
    for (int ph = 0; ph < 3; ph++) begin
      sink_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 10 : 0;
      for (int k = 0; k < 95; k++)
        send_bar(rand_bar(), (ph == 0) ? 10 : (ph == 1) ? 48 : 0);
    end
    bar_if.valid <= 1'b0;
    sink_idle_pct = 0;
    while (entry_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
